>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the receiver frame decoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/rcfd_pkg.sv
// Package of the receiver frame decoder: types, register codes and constants.
// No dependencies; imported by every module of the block.
`default_nettype none

package rcfd_pkg;

	// Frame bytes kept in the byte cell chain
	localparam int STORE_DEPTH = 16;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 13;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE = 8'd3;

	// Register reset values
	localparam logic [9:0]  RST_DEADBAND = 10'd10;
	localparam logic [10:0] RST_CENTER   = 11'd1024;
	localparam logic [12:0] RST_LIMIT    = 13'd8000;
	localparam logic [1:0]  RST_FAILSAFE = 2'd3;

	localparam logic signed [11:0] CH_MAX = 12'sd1023;
	localparam logic signed [11:0] CH_MIN = -12'sd1024;

	typedef struct packed {
		logic [9:0]  deadband;
		logic [10:0] center;
		logic [12:0] limit;
		logic [1:0]  failsafe;
	} rcfd_cfg_t;

	typedef struct packed {
		logic signed [10:0] value;
		logic               bad;
	} rcfd_chan_t;

endpackage

`default_nettype wire

>>> rtl/core/rc_receiver_frame_decoder_top.sv
// Top level of the remote-control receiver frame decoder.
// Depends on rcfd_pkg, rcfd_byte_cell, rcfd_chan_unit and assert_macros.svh.
//
// Input channel (in_valid / in_stall): one transaction carries rx_byte and
// frame_start. frame_start makes the byte position 0 of a new frame. Bytes
// at positions below 16 shift into a chain of 16 byte cells; later bytes
// are only counted. The byte at position FRAME_LEN-1 completes the frame.
// Output channel (out_valid / out_stall): one transaction per completed
// frame with the decoded sticks, switches, mouse, keys and frame_error.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
// registers only while no frame is in flight. Indexes above 3 are ignored.
// Throughput: one byte per cycle while in_stall is low. The edge that takes
// the last byte loads the capture stage; the decoded frame then goes into
// the output register, where out_valid marks it.
// Reset: byte count and stages clear, registers take their defaults.
// Stall: a waiting result holds; one more completed frame parks in the
// capture stage, after which in_stall rises until the output drains.
`default_nettype none
`include "assert_macros.svh"

module rc_receiver_frame_decoder_top
	import rcfd_pkg::*;
#(
	parameter int FRAME_LEN = 18
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input byte channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            rx_byte,
	input  wire logic                  frame_start,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [10:0]         stick_ch0,
	output logic signed [10:0]         stick_ch1,
	output logic signed [10:0]         stick_ch2,
	output logic signed [10:0]         stick_ch3,
	output logic        [1:0]          switch_left,
	output logic        [1:0]          switch_right,
	output logic signed [15:0]         mouse_dx,
	output logic signed [15:0]         mouse_dy,
	output logic signed [15:0]         mouse_dz,
	output logic        [15:0]         mouse_buttons,
	output logic        [15:0]         key_word,
	output logic                       frame_error,
	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [4:0] LAST_POS      = 5'(FRAME_LEN - 1);
	localparam logic [4:0] STORE_LIMIT   = 5'(STORE_DEPTH);
	// With a 16-byte frame the last byte is still in flight at decode time
	localparam bit         LAST_IN_STORE = (FRAME_LEN == STORE_DEPTH);

	rcfd_cfg_t  cfg_q;
	logic [4:0] byte_count_q;
	logic [4:0] pos;
	logic       in_accept;
	logic       frame_done;
	logic       shift_en;

	logic [7:0] cell_q [STORE_DEPTH];
	logic [7:0] frame  [STORE_DEPTH];

	logic       s1_valid_q;
	logic       s1_adv;
	logic [7:0] frame_s1 [STORE_DEPTH];

	rcfd_chan_t chan [4];
	logic [1:0] sw_l;
	logic [1:0] sw_r;
	logic       bad;

	logic              out_valid_q;
	logic signed [10:0] stick_q [4];
	logic [1:0]        switch_left_q;
	logic [1:0]        switch_right_q;
	logic [15:0]       mouse_dx_q;
	logic [15:0]       mouse_dy_q;
	logic [15:0]       mouse_dz_q;
	logic [15:0]       mouse_buttons_q;
	logic [15:0]       key_word_q;
	logic              frame_error_q;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband <= RST_DEADBAND;
			cfg_q.center   <= RST_CENTER;
			cfg_q.limit    <= RST_LIMIT;
			cfg_q.failsafe <= RST_FAILSAFE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEADBAND: cfg_q.deadband <= cfg_data[9:0];
				CFG_CENTER:   cfg_q.center   <= cfg_data[10:0];
				CFG_LIMIT:    cfg_q.limit    <= cfg_data[12:0];
				CFG_FAILSAFE: cfg_q.failsafe <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Byte position and input handshake
	// ------------------------------------------------------------------
	// Advance the capture stage when the output register is free or drains
	assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall   = s1_valid_q && !s1_adv;
	assign in_accept  = in_valid && !in_stall;
	assign pos        = frame_start ? 5'd0 : byte_count_q;
	assign frame_done = in_accept && (pos == LAST_POS);
	assign shift_en   = in_accept && (pos < STORE_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 5'd0;
		end else if (in_accept) begin
			// return to position 0 after the last byte, else count on
			byte_count_q <= (pos == LAST_POS) ? 5'd0 : pos + 5'd1;
		end
	end

	// ------------------------------------------------------------------
	// Byte cell chain: newest byte in cell 0, oldest in the last cell
	// ------------------------------------------------------------------
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		logic [7:0] cell_d;
		if (i == 0) begin : g_head
			assign cell_d = rx_byte;
		end else begin : g_link
			assign cell_d = cell_q[i-1];
		end
		rcfd_byte_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (cell_d),
			.q        (cell_q[i])
		);
	end

	// Map chain cells to frame byte order at the decode point
	always_comb begin
		for (int k = 0; k < STORE_DEPTH - 1; k++) begin
			frame[k] = LAST_IN_STORE ? cell_q[STORE_DEPTH-2-k] : cell_q[STORE_DEPTH-1-k];
		end
		frame[STORE_DEPTH-1] = LAST_IN_STORE ? rx_byte : cell_q[0];
	end

	// ------------------------------------------------------------------
	// Capture stage: hold the completed frame
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (frame_done) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			frame_s1 <= frame;
		end
	end

	// ------------------------------------------------------------------
	// Decode: unpack the channels and check the frame
	// ------------------------------------------------------------------
	rcfd_chan_unit u_ch0 (
		.raw ({frame_s1[1][2:0], frame_s1[0]}),
		.cfg (cfg_q),
		.res (chan[0])
	);
	rcfd_chan_unit u_ch1 (
		.raw ({frame_s1[2][5:0], frame_s1[1][7:3]}),
		.cfg (cfg_q),
		.res (chan[1])
	);
	rcfd_chan_unit u_ch2 (
		.raw ({frame_s1[4][0], frame_s1[3], frame_s1[2][7:6]}),
		.cfg (cfg_q),
		.res (chan[2])
	);
	rcfd_chan_unit u_ch3 (
		.raw ({frame_s1[5][3:0], frame_s1[4][7:1]}),
		.cfg (cfg_q),
		.res (chan[3])
	);

	assign sw_l = frame_s1[5][7:6];
	assign sw_r = frame_s1[5][5:4];
	assign bad  = chan[0].bad || chan[1].bad || chan[2].bad || chan[3].bad ||
		(sw_l == 2'd0) || (sw_r == 2'd0);

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			if (bad) begin
				// substitute the fail-safe frame
				for (int c = 0; c < 4; c++) begin
					stick_q[c] <= 11'sd0;
				end
				switch_left_q   <= cfg_q.failsafe;
				switch_right_q  <= cfg_q.failsafe;
				mouse_dx_q      <= 16'd0;
				mouse_dy_q      <= 16'd0;
				mouse_dz_q      <= 16'd0;
				mouse_buttons_q <= 16'd0;
				key_word_q      <= 16'd0;
				frame_error_q   <= 1'b1;
			end else begin
				for (int c = 0; c < 4; c++) begin
					stick_q[c] <= chan[c].value;
				end
				switch_left_q   <= sw_l;
				switch_right_q  <= sw_r;
				mouse_dx_q      <= {frame_s1[7], frame_s1[6]};
				mouse_dy_q      <= {frame_s1[9], frame_s1[8]};
				mouse_dz_q      <= {frame_s1[11], frame_s1[10]};
				mouse_buttons_q <= {frame_s1[13], frame_s1[12]};
				key_word_q      <= {frame_s1[15], frame_s1[14]};
				frame_error_q   <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign stick_ch0     = stick_q[0];
	assign stick_ch1     = stick_q[1];
	assign stick_ch2     = stick_q[2];
	assign stick_ch3     = stick_q[3];
	assign switch_left   = switch_left_q;
	assign switch_right  = switch_right_q;
	assign mouse_dx      = $signed(mouse_dx_q);
	assign mouse_dy      = $signed(mouse_dy_q);
	assign mouse_dz      = $signed(mouse_dz_q);
	assign mouse_buttons = mouse_buttons_q;
	assign key_word      = key_word_q;
	assign frame_error   = frame_error_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// A fail-safe result carries zeroed channels, mouse buttons and keys
	`ASSERT_IMPL(a_failsafe_zero, clk, arst_n, out_valid && frame_error, stick_ch0 == 11'sd0 && stick_ch1 == 11'sd0 && stick_ch2 == 11'sd0 && stick_ch3 == 11'sd0 && mouse_buttons == 16'd0 && key_word == 16'd0)
	// Stall only while a completed frame is parked in the capture stage
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, s1_valid_q && out_valid_q && out_stall)
	// The last byte of a frame fills the capture stage
	`ASSERT_NEXT(a_capture, clk, arst_n, frame_done, s1_valid_q)
	// A start marker restarts the count at the next position
	`ASSERT_NEXT(a_restart, clk, arst_n, in_accept && frame_start, byte_count_q == 5'd1)

endmodule

`default_nettype wire

>>> rtl/core/rcfd_byte_cell.sv
// One byte cell of the frame store chain: loads its left neighbor's byte.
// Depends on rcfd_pkg only; chained by the top level.
`default_nettype none

module rcfd_byte_cell
	import rcfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       shift_en,
	input  wire logic [7:0] d,
	output logic      [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

`default_nettype wire

>>> rtl/core/rcfd_chan_unit.sv
// Stick channel unit: centre, deadband, limit check and saturation.
// Depends on rcfd_pkg for the config and channel result structs.
`default_nettype none

module rcfd_chan_unit
	import rcfd_pkg::*;
(
	input  wire logic [10:0] raw,
	input  wire rcfd_cfg_t   cfg,
	output rcfd_chan_t       res
);

	logic signed [11:0] diff;
	logic        [10:0] mag;
	logic        [10:0] mag_eff;
	logic               in_db;

	always_comb begin
		diff    = $signed({1'b0, raw}) - $signed({1'b0, cfg.center});
		mag     = diff[11] ? 11'(-diff) : diff[10:0];
		in_db   = mag < {1'b0, cfg.deadband};
		mag_eff = in_db ? 11'd0 : mag;
		res.bad = {2'b00, mag_eff} > cfg.limit;
		// saturate the centred value to the 11-bit output range
		if (in_db) begin
			res.value = 11'sd0;
		end else if (diff > CH_MAX) begin
			res.value = CH_MAX[10:0];
		end else if (diff < CH_MIN) begin
			res.value = CH_MIN[10:0];
		end else begin
			res.value = diff[10:0];
		end
	end

endmodule

`default_nettype wire
